@@ design/pwfp_pkg.sv @@
// pwfp_pkg: shared types and codes for the protobuf wire field parser
package pwfp_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PHASE_TAG     = 3'd0,
      PHASE_VARVAL  = 3'd1,
      PHASE_FIXED   = 3'd2,
      PHASE_LENVAR  = 3'd3,
      PHASE_PAYLOAD = 3'd4
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_FIELD   = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2,
      KIND_ERROR   = 2'd3
   } kind_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_BAD_TAG   = 3'd1,
      ERR_BAD_WIRE  = 3'd2,
      ERR_BAD_VALUE = 3'd3,
      ERR_BAD_LEN   = 3'd4,
      ERR_TRUNC     = 3'd5
   } error_type;

   // supported wire types
   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LENDEL  = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   localparam logic [3:0] FIXED64_BYTES = 4'd8;
   localparam logic [3:0] FIXED32_BYTES = 4'd4;

   // input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_end;
   } req_type;

   // result transaction
   typedef struct packed {
      kind_type           kind;
      logic [60:0]        field_id;
      logic [2:0]         wire_kind;
      logic [63:0]        raw_value;
      logic               fits_32;
      logic signed [63:0] zigzag_value;
      logic [7:0]         payload_byte;
      error_type          error_code;
      logic               last_of_message;
   } rsp_type;

endpackage

@@ design/protobuf_wire_field_parser.sv @@
// protobuf_wire_field_parser: byte-wide protobuf wire-format field parser
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   pwfp_pkg::req_type
//   rsp       out        rsp_valid/rsp_stall   pwfp_pkg::rsp_type
//   csr       in         csr_valid/csr_ready   csr_data (emit_payload)
//
// One byte a cycle while no result is held by rsp_stall: a byte sits in the
// input register, the parse step runs against the state registers, and its
// result lands in the output register, which drives rsp.
// Reset is synchronous and puts the parser back to awaiting a tag.
// While a result is held by rsp_stall, the input register still takes one
// byte; after that req_stall rises until the output register drains.
// csr_ready is always high.
module protobuf_wire_field_parser #(
   parameter int MAX_VARINT_BYTES = 10,
   parameter int LENGTH_BITS      = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pwfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pwfp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   localparam int CW = $clog2(MAX_VARINT_BYTES + 1);

   // input register
   logic              in_valid_ff;
   pwfp_pkg::req_type in_data_ff;
   // output register
   logic              out_valid_ff;
   pwfp_pkg::rsp_type out_data_ff;
   // parser state
   pwfp_pkg::phase_type phase_ff, phase_in;
   logic [63:0]         acc_ff, acc_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [60:0]         fid_ff, fid_in;
   logic [2:0]          wk_ff, wk_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                disc_ff, disc_in;
   logic                emit_ff;

   logic              fire;
   logic              res_valid;
   pwfp_pkg::rsp_type res;

   // step fires when a byte waits and the output register can take a result
   assign fire      = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // byte decode
   logic [7:0]    b;
   logic          end_flag;
   logic [6:0]    take_sh;
   logic [63:0]   acc_take;
   logic [CW-1:0] cnt_take;
   logic          var_done;
   logic          var_long;
   logic [3:0]    fix_cnt;
   logic [3:0]    fix_need;
   logic [63:0]   fix_acc;
   logic          fix_done;
   logic [2:0]    tag_wk;
   logic          tag_bad_wk;
   logic          len_big;
   logic          len_zero;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic          rem_zero;

   assign b        = in_data_ff.data_byte;
   assign end_flag = in_data_ff.message_end;
   assign take_sh  = 7'(cnt_ff) * 7'd7;
   assign acc_take = acc_ff | (64'(b[6:0]) << take_sh);
   assign cnt_take = cnt_ff + 1'b1;
   assign var_done = !b[7];
   assign var_long = b[7] && (cnt_take >= CW'(MAX_VARINT_BYTES));
   assign fix_cnt  = {1'b0, cnt_ff[2:0]} + 4'd1;
   assign fix_need = (wk_ff == pwfp_pkg::WIRE_FIXED64) ? pwfp_pkg::FIXED64_BYTES
                                                       : pwfp_pkg::FIXED32_BYTES;
   assign fix_acc  = acc_ff | (64'(b) << {cnt_ff[2:0], 3'b000});
   assign fix_done = fix_cnt >= fix_need;
   assign tag_wk   = acc_take[2:0];
   assign tag_bad_wk = !(tag_wk == pwfp_pkg::WIRE_VARINT || tag_wk == pwfp_pkg::WIRE_FIXED64 ||
                         tag_wk == pwfp_pkg::WIRE_LENDEL || tag_wk == pwfp_pkg::WIRE_FIXED32);
   assign len_big  = |acc_take[63:LENGTH_BITS];
   assign len_zero = (acc_take == 64'd0);
   assign rem_dec  = rem_ff - 1'b1;
   assign rem_zero = (rem_dec == '0);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (disc_ff) begin
         phase_in = pwfp_pkg::PHASE_TAG;
      end else begin
         unique case (phase_ff)
            pwfp_pkg::PHASE_TAG: begin
               phase_in = pwfp_pkg::PHASE_TAG;
               if (var_done && !tag_bad_wk && !end_flag) begin
                  if (tag_wk == pwfp_pkg::WIRE_VARINT) begin
                     phase_in = pwfp_pkg::PHASE_VARVAL;
                  end else if (tag_wk == pwfp_pkg::WIRE_LENDEL) begin
                     phase_in = pwfp_pkg::PHASE_LENVAR;
                  end else begin
                     phase_in = pwfp_pkg::PHASE_FIXED;
                  end
               end
            end
            pwfp_pkg::PHASE_VARVAL: begin
               if (var_done || var_long || end_flag) phase_in = pwfp_pkg::PHASE_TAG;
            end
            pwfp_pkg::PHASE_FIXED: begin
               if (fix_done || end_flag) phase_in = pwfp_pkg::PHASE_TAG;
            end
            pwfp_pkg::PHASE_LENVAR: begin
               if (var_long || end_flag) begin
                  phase_in = pwfp_pkg::PHASE_TAG;
               end else if (var_done) begin
                  phase_in = (len_big || len_zero) ? pwfp_pkg::PHASE_TAG
                                                   : pwfp_pkg::PHASE_PAYLOAD;
               end
            end
            pwfp_pkg::PHASE_PAYLOAD: begin
               if (rem_zero || end_flag) phase_in = pwfp_pkg::PHASE_TAG;
            end
            default: phase_in = pwfp_pkg::PHASE_TAG;
         endcase
      end
   end

   // datapath state and result
   always_comb begin
      logic               do_fail;
      logic               do_done;
      pwfp_pkg::error_type code;
      logic [63:0]        raw;

      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      fid_in    = fid_ff;
      wk_in     = wk_ff;
      rem_in    = rem_ff;
      disc_in   = disc_ff;
      res_valid = 1'b0;
      res       = '0;
      do_fail   = 1'b0;
      do_done   = 1'b0;
      code      = pwfp_pkg::ERR_NONE;
      raw       = '0;

      if (disc_ff) begin
         // dropping the rest of a bad message
         if (end_flag) begin
            disc_in   = 1'b0;
            acc_in    = '0;
            cnt_in    = '0;
            res_valid = 1'b1;
            res.kind  = pwfp_pkg::KIND_END;
            res.last_of_message = 1'b1;
         end
      end else begin
         unique case (phase_ff)
            pwfp_pkg::PHASE_TAG: begin
               acc_in = acc_take;
               cnt_in = cnt_take;
               if (var_long) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_BAD_TAG;
               end else if (!var_done) begin
                  if (end_flag) begin
                     do_fail = 1'b1;
                     code    = pwfp_pkg::ERR_TRUNC;
                  end
               end else begin
                  fid_in = acc_take[63:3];
                  wk_in  = tag_wk;
                  acc_in = '0;
                  cnt_in = '0;
                  if (tag_bad_wk) begin
                     do_fail = 1'b1;
                     code    = pwfp_pkg::ERR_BAD_WIRE;
                  end else if (end_flag) begin
                     do_fail = 1'b1;
                     code    = pwfp_pkg::ERR_TRUNC;
                  end
               end
            end
            pwfp_pkg::PHASE_VARVAL: begin
               acc_in = acc_take;
               cnt_in = cnt_take;
               if (var_long) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_BAD_VALUE;
               end else if (!var_done) begin
                  if (end_flag) begin
                     do_fail = 1'b1;
                     code    = pwfp_pkg::ERR_TRUNC;
                  end
               end else begin
                  do_done = 1'b1;
                  raw     = acc_take;
               end
            end
            pwfp_pkg::PHASE_FIXED: begin
               acc_in = fix_acc;
               cnt_in = CW'(fix_cnt);
               if (fix_done) begin
                  do_done = 1'b1;
                  raw     = fix_acc;
               end else if (end_flag) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_TRUNC;
               end
            end
            pwfp_pkg::PHASE_LENVAR: begin
               acc_in = acc_take;
               cnt_in = cnt_take;
               if (var_long) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_BAD_LEN;
               end else if (!var_done) begin
                  if (end_flag) begin
                     do_fail = 1'b1;
                     code    = pwfp_pkg::ERR_TRUNC;
                  end
               end else if (len_big) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_BAD_LEN;
               end else if (!len_zero && end_flag) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_TRUNC;
               end else begin
                  do_done = 1'b1;
                  raw     = acc_take;
                  if (!len_zero) rem_in = acc_take[LENGTH_BITS-1:0];
               end
            end
            pwfp_pkg::PHASE_PAYLOAD: begin
               rem_in = rem_dec;
               if (end_flag && !rem_zero) begin
                  do_fail = 1'b1;
                  code    = pwfp_pkg::ERR_TRUNC;
               end else if (emit_ff) begin
                  res_valid            = 1'b1;
                  res.kind             = pwfp_pkg::KIND_PAYLOAD;
                  res.field_id         = fid_ff;
                  res.wire_kind        = wk_ff;
                  res.payload_byte     = b;
                  res.last_of_message  = end_flag;
               end else if (end_flag) begin
                  res_valid           = 1'b1;
                  res.kind            = pwfp_pkg::KIND_END;
                  res.last_of_message = 1'b1;
               end
            end
            default: begin
               acc_in = '0;
               cnt_in = '0;
            end
         endcase

         // field complete
         if (do_done) begin
            acc_in              = '0;
            cnt_in              = '0;
            res_valid           = 1'b1;
            res.kind            = pwfp_pkg::KIND_FIELD;
            res.field_id        = fid_ff;
            res.wire_kind       = wk_ff;
            res.raw_value       = raw;
            res.fits_32         = (raw[63:32] == 32'd0);
            res.zigzag_value    = {1'b0, raw[63:1]} ^ {64{raw[0]}};
            res.last_of_message = end_flag;
         end

         // error: drop the rest of the message unless this byte ends it
         if (do_fail) begin
            acc_in              = '0;
            cnt_in              = '0;
            rem_in              = '0;
            disc_in             = !end_flag;
            res_valid           = 1'b1;
            res.kind            = pwfp_pkg::KIND_ERROR;
            res.error_code      = code;
            res.last_of_message = end_flag;
         end
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (fire || !in_valid_ff) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (fire || !in_valid_ff) begin
         in_data_ff <= req_data;
      end
   end

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= res_valid;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= res;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pwfp_pkg::PHASE_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         fid_ff   <= '0;
         wk_ff    <= '0;
         rem_ff   <= '0;
         disc_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         fid_ff   <= fid_in;
         wk_ff    <= wk_in;
         rem_ff   <= rem_in;
         disc_ff  <= disc_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         emit_ff <= csr_data;
      end
   end

endmodule

@@ design/pwfp_checker.sv @@
// pwfp_checker: port-level checks on the result channel of the field parser
module pwfp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pwfp_pkg::rsp_type rsp_data
);

   // a stalled result transaction stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // completed field flags match the value width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == pwfp_pkg::KIND_FIELD |->
         rsp_data.fits_32 == (rsp_data.raw_value[63:32] == 32'd0) &&
         rsp_data.error_code == pwfp_pkg::ERR_NONE)
      else $error("field result with bad flags");

   // errors carry a code and no field data, message end is always last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == pwfp_pkg::KIND_ERROR ||
                    rsp_data.kind == pwfp_pkg::KIND_END) |->
         rsp_data.field_id == 61'd0 && rsp_data.raw_value == 64'd0 &&
         (rsp_data.kind == pwfp_pkg::KIND_ERROR ? rsp_data.error_code != pwfp_pkg::ERR_NONE
                                                 : rsp_data.last_of_message))
      else $error("error or end result malformed");

endmodule

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (.*);

@@ tb/tb.sv @@
// tb: self-checking testbench for the protobuf wire field parser
`timescale 1ns / 1ps

module tb;
   import pwfp_pkg::*;

   localparam int          MAX_VARINT_BYTES = 10;
   localparam int          LENGTH_BITS      = 32;
   localparam logic [63:0] MAX_LENGTH       = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam int          SETTLE_CYCLES    = 6;
   localparam int          LONG_HOLD_CYCLES = 80;
   localparam int          WATCHDOG_LIMIT   = 2000;

   // outcome of folding one byte into a varint
   typedef enum int {VARINT_MORE, VARINT_DONE, VARINT_TOO_LONG} varint_status_type;

   // ways a generated field can be broken
   typedef enum int {
      DEFECT_NONE,
      DEFECT_WIRE,
      DEFECT_LONG_TAG,
      DEFECT_LONG_VALUE,
      DEFECT_HUGE_LEN,
      DEFECT_CUT_PAYLOAD
   } defect_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   // parser state as the block should hold it
   phase_type   parse_phase  = PHASE_TAG;
   logic [63:0] varint_acc   = '0;
   logic [3:0]  varint_len   = '0;
   logic [60:0] field_num    = '0;
   logic [2:0]  field_wire   = '0;
   logic [31:0] payload_left = '0;
   bit          skip_to_end  = 1'b0;
   bit          emit_payload = 1'b0;

   rsp_type    parse_results_due[$];
   logic [7:0] msg_buf[$];
   int         bytes_parsed      = 0;
   int         error_count       = 0;
   int         quiet_cycles      = 0;
   bit         idle_on           = 1'b1;
   bit         long_hold_request = 1'b0;

   protobuf_wire_field_parser #(
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES),
      .LENGTH_BITS     (LENGTH_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- parser prediction

   function automatic rsp_type make_result(kind_type kind, logic [60:0] fid, logic [2:0] wk,
                                           logic [63:0] raw, logic [7:0] pb, error_type err,
                                           bit last);
      rsp_type r;
      r = '0;
      r.kind      = kind;
      r.field_id  = fid;
      r.wire_kind = wk;
      if (kind == KIND_FIELD) begin
         r.raw_value    = raw;
         r.fits_32      = (raw <= 64'hFFFF_FFFF);
         r.zigzag_value = (raw >> 1) ^ {64{raw[0]}};
      end
      r.payload_byte    = pb;
      r.error_code      = err;
      r.last_of_message = last;
      return r;
   endfunction

   function automatic void clear_varint();
      varint_acc = '0;
      varint_len = '0;
   endfunction

   function automatic bit is_supported_wire(logic [2:0] wt);
      return wt == WIRE_VARINT || wt == WIRE_FIXED64 || wt == WIRE_LENDEL ||
             wt == WIRE_FIXED32;
   endfunction

   // bits beyond bit 63 of an overlong varint fall away
   function automatic varint_status_type fold_varint_byte(logic [7:0] b);
      int shift;
      shift = 7 * varint_len;
      if (shift < 64)
         varint_acc = varint_acc | ({57'd0, b[6:0]} << shift);
      varint_len = varint_len + 4'd1;
      if (!b[7])
         return VARINT_DONE;
      if (varint_len >= MAX_VARINT_BYTES)
         return VARINT_TOO_LONG;
      return VARINT_MORE;
   endfunction

   // error: drop the rest of the message unless this byte already ends it
   function automatic rsp_type abort_message(error_type code, bit last);
      clear_varint();
      parse_phase  = PHASE_TAG;
      payload_left = '0;
      skip_to_end  = !last;
      return make_result(KIND_ERROR, '0, '0, '0, '0, code, last);
   endfunction

   function automatic rsp_type finish_field(logic [63:0] raw, bit last);
      rsp_type r;
      r = make_result(KIND_FIELD, field_num, field_wire, raw, '0, ERR_NONE, last);
      clear_varint();
      parse_phase = PHASE_TAG;
      return r;
   endfunction

   task automatic predict_parse(input logic [7:0] b, input bit last, output bit got,
                                output rsp_type r);
      varint_status_type st;
      logic [3:0]        need;
      logic [2:0]        cnt;
      logic [63:0]       len;
      got = 1'b1;
      r   = '0;
      if (skip_to_end) begin
         // dropping bytes after an error until the message ends
         got = last;
         if (last) begin
            skip_to_end = 1'b0;
            parse_phase = PHASE_TAG;
            clear_varint();
            r = make_result(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b1);
         end
      end else begin
         case (parse_phase)
            PHASE_VARVAL: begin
               st = fold_varint_byte(b);
               if (st == VARINT_TOO_LONG)
                  r = abort_message(ERR_BAD_VALUE, last);
               else if (st == VARINT_MORE) begin
                  got = last;
                  if (last) r = abort_message(ERR_TRUNC, last);
               end else
                  r = finish_field(varint_acc, last);
            end
            PHASE_FIXED: begin
               // little-endian fixed-width value
               need       = (field_wire == WIRE_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
               cnt        = varint_len[2:0];
               varint_acc = varint_acc | ({56'd0, b} << (8 * cnt));
               varint_len = cnt + 4'd1;
               if (varint_len >= need)
                  r = finish_field(varint_acc, last);
               else begin
                  got = last;
                  if (last) r = abort_message(ERR_TRUNC, last);
               end
            end
            PHASE_LENVAR: begin
               st = fold_varint_byte(b);
               if (st == VARINT_TOO_LONG)
                  r = abort_message(ERR_BAD_LEN, last);
               else if (st == VARINT_MORE) begin
                  got = last;
                  if (last) r = abort_message(ERR_TRUNC, last);
               end else begin
                  len = varint_acc;
                  if (len > MAX_LENGTH)
                     r = abort_message(ERR_BAD_LEN, last);
                  else if (len != 0 && last)
                     r = abort_message(ERR_TRUNC, last);
                  else begin
                     r = finish_field(len, last);
                     if (len != 0) begin
                        payload_left = len[31:0];
                        parse_phase  = PHASE_PAYLOAD;
                     end
                  end
               end
            end
            PHASE_PAYLOAD: begin
               if (payload_left != 0) payload_left = payload_left - 1;
               if (payload_left == 0) parse_phase = PHASE_TAG;
               if (last && payload_left != 0)
                  r = abort_message(ERR_TRUNC, last);
               else begin
                  if (last) parse_phase = PHASE_TAG;
                  if (emit_payload)
                     r = make_result(KIND_PAYLOAD, field_num, field_wire, '0, b, ERR_NONE,
                                     last);
                  else begin
                     // skipped byte: only the final one reports
                     got = last;
                     if (last) r = make_result(KIND_END, '0, '0, '0, '0, ERR_NONE, 1'b1);
                  end
               end
            end
            default: begin
               parse_phase = PHASE_TAG;
               st = fold_varint_byte(b);
               if (st == VARINT_TOO_LONG)
                  r = abort_message(ERR_BAD_TAG, last);
               else if (st == VARINT_MORE) begin
                  got = last;
                  if (last) r = abort_message(ERR_TRUNC, last);
               end else begin
                  field_num  = varint_acc[63:3];
                  field_wire = varint_acc[2:0];
                  clear_varint();
                  if (!is_supported_wire(field_wire))
                     r = abort_message(ERR_BAD_WIRE, last);
                  else if (last)
                     r = abort_message(ERR_TRUNC, last);
                  else begin
                     got = 1'b0;
                     case (field_wire)
                        WIRE_VARINT: parse_phase = PHASE_VARVAL;
                        WIRE_LENDEL: parse_phase = PHASE_LENVAR;
                        default:     parse_phase = PHASE_FIXED;
                     endcase
                  end
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- message building

   function automatic logic [63:0] random_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return v >> $urandom_range(0, 63);
      endcase
   endfunction

   // shortest encoding, sometimes padded out to a random length up to MAX_VARINT_BYTES
   function automatic void put_varint(logic [63:0] v);
      int          need;
      int          total;
      logic [63:0] part;
      logic [7:0]  b;
      need = 1;
      while (need < MAX_VARINT_BYTES && (v >> (7 * need)) != 0) need++;
      total = ($urandom_range(0, 7) == 0) ? $urandom_range(need, MAX_VARINT_BYTES) : need;
      for (int i = 0; i < total; i++) begin
         part = v >> (7 * i);
         b    = {1'b0, part[6:0]};
         if (i < total - 1)
            b[7] = 1'b1;
         else if (i == MAX_VARINT_BYTES - 1)
            b[6:1] = 6'($urandom);
         msg_buf.push_back(b);
      end
   endfunction

   function automatic void put_random_bytes(int count);
      repeat (count) msg_buf.push_back(8'($urandom));
   endfunction

   // varint whose last allowed byte still continues
   function automatic void put_overlong_varint();
      repeat (MAX_VARINT_BYTES) msg_buf.push_back({1'b1, 7'($urandom)});
      put_random_bytes($urandom_range(0, 2));
   endfunction

   function automatic void build_message();
      logic [60:0] id;
      logic [2:0]  wt;
      logic [63:0] len;
      defect_type  defect;
      msg_buf.delete();
      if ($urandom_range(0, 15) == 0) begin
         // plain noise
         put_random_bytes($urandom_range(1, 12));
         return;
      end
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 3) == 0)
            id = 61'({$urandom, $urandom} >> $urandom_range(0, 63));
         else
            id = 61'($urandom_range(0, 20));
         defect = DEFECT_NONE;
         if ($urandom_range(0, 4) == 0)
            defect = defect_type'($urandom_range(DEFECT_WIRE, DEFECT_CUT_PAYLOAD));
         case (defect)
            DEFECT_WIRE: begin
               wt = 3'($urandom_range(0, 7));
               while (is_supported_wire(wt)) wt = 3'($urandom_range(0, 7));
               put_varint({id, wt});
               put_random_bytes($urandom_range(0, 3));
            end
            DEFECT_LONG_TAG:
               put_overlong_varint();
            DEFECT_LONG_VALUE: begin
               put_varint({id, ($urandom_range(0, 1) == 0) ? WIRE_VARINT : WIRE_LENDEL});
               put_overlong_varint();
            end
            DEFECT_HUGE_LEN: begin
               put_varint({id, WIRE_LENDEL});
               if ($urandom_range(0, 3) == 0)
                  len = MAX_LENGTH + 64'd1;
               else
                  len = random_value() | (64'd1 << $urandom_range(LENGTH_BITS, 63));
               put_varint(len);
               put_random_bytes($urandom_range(0, 3));
            end
            DEFECT_CUT_PAYLOAD: begin
               // long payload that the message end cuts short
               put_varint({id, WIRE_LENDEL});
               if ($urandom_range(0, 3) == 0)
                  len = MAX_LENGTH;
               else
                  len = 64'($urandom_range(7, 32'hFFFF_FFFF));
               put_varint(len);
               put_random_bytes($urandom_range(0, 6));
            end
            default: begin
               wt = 3'($urandom_range(0, 7));
               while (!is_supported_wire(wt)) wt = 3'($urandom_range(0, 7));
               put_varint({id, wt});
               case (wt)
                  WIRE_VARINT:  put_varint(random_value());
                  WIRE_FIXED64: put_random_bytes(int'(FIXED64_BYTES));
                  WIRE_FIXED32: put_random_bytes(int'(FIXED32_BYTES));
                  default: begin
                     len = 64'($urandom_range(0, 6));
                     put_varint(len);
                     put_random_bytes(int'(len));
                  end
               endcase
            end
         endcase
      end
      // sometimes the message stops early
      if ($urandom_range(0, 7) == 0 && msg_buf.size() > 1)
         repeat ($urandom_range(1, msg_buf.size() - 1)) void'(msg_buf.pop_back());
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_byte(input logic [7:0] b, input bit last);
      int      gap;
      bit      got;
      rsp_type r;
      gap = idle_on ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, message_end: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_parsed++;
      predict_parse(b, last, got, r);
      if (got) parse_results_due.push_back(r);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_buf.size(); i++)
         send_byte(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   // stop sending until every result is out and the pipeline is empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (parse_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_emit_payload(input bit value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid    <= 1'b0;
      emit_payload = value;
   endtask

   // ---------------------------------------------------------------- tests

   // payload skipped by default after reset, final byte reports message end
   task automatic test_reset_default();
      msg_buf = '{8'h12, 8'h02, 8'hAA, 8'h55};
      send_message();
   endtask

   task automatic test_directed_cases();
      // varint zero, then fixed32 all ones
      msg_buf = '{8'h08, 8'h00};
      send_message();
      msg_buf = '{8'h0D, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_message();
      // forwarded payload, final byte inside it
      msg_buf = '{8'h12, 8'h02, 8'h00, 8'hFF};
      send_message();
      // zero-length field goes straight back to a tag
      msg_buf = '{8'h12, 8'h00, 8'h08, 8'h7F};
      send_message();
      // unsupported wire type, rest dropped until message end
      msg_buf = '{8'h1B, 8'h00, 8'h00};
      send_message();
      // message ends right after a tag, then inside a tag
      msg_buf = '{8'h08};
      send_message();
      msg_buf = '{8'h80};
      send_message();
      // tag too long on the final byte: too-long wins over truncation
      msg_buf.delete();
      repeat (MAX_VARINT_BYTES) msg_buf.push_back(8'hFF);
      send_message();
   endtask

   task automatic test_random_stream(input int target);
      int start;
      start = bytes_parsed;
      while (bytes_parsed - start < target) begin
         build_message();
         send_message();
      end
   endtask

   // receiver holds off a long time while bytes keep coming with no gaps
   task automatic test_backpressure();
      idle_on           = 1'b0;
      long_hold_request = 1'b1;
      test_random_stream(120);
      idle_on = 1'b1;
   endtask

   // sender stops mid-message until everything has drained
   task automatic test_sender_pause();
      msg_buf = '{8'h0A, 8'h04, 8'h11, 8'h22, 8'h33, 8'h44, 8'h10, 8'h01};
      for (int i = 0; i < 3; i++) send_byte(msg_buf[i], 1'b0);
      wait_idle();
      for (int i = 3; i < msg_buf.size(); i++) send_byte(msg_buf[i], i == msg_buf.size() - 1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_default();
      wait_idle();
      write_emit_payload(1'b1);
      test_directed_cases();
      test_backpressure();
      test_random_stream(550);
      wait_idle();
      write_emit_payload(1'b0);
      test_random_stream(550);
      wait_idle();
      write_emit_payload(1'b1);
      test_sender_pause();
      wait_idle();
      if (error_count == 0 && parse_results_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // result stall: random per transaction, or one long hold when asked
   initial begin : rsp_stall_driver
      int hold;
      forever begin
         if (long_hold_request) begin
            hold              = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
         end else
            hold = idle_on ? $urandom_range(0, 19) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         error_count++;
      end
   endtask

   // compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parse_results_due.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_data);
            error_count++;
         end else begin
            want = parse_results_due.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_data.kind));
            check_field("field_id", 64'(want.field_id), 64'(rsp_data.field_id));
            check_field("wire_kind", 64'(want.wire_kind), 64'(rsp_data.wire_kind));
            check_field("raw_value", want.raw_value, rsp_data.raw_value);
            check_field("fits_32", 64'(want.fits_32), 64'(rsp_data.fits_32));
            check_field("zigzag_value", want.zigzag_value, rsp_data.zigzag_value);
            check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_data.payload_byte));
            check_field("error_code", 64'(want.error_code), 64'(rsp_data.error_code));
            check_field("last_of_message", 64'(want.last_of_message),
                        64'(rsp_data.last_of_message));
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

@@ protobuf_wire_field_parser.f @@
design/pwfp_pkg.sv
design/protobuf_wire_field_parser.sv
design/pwfp_checker.sv
tb/tb.sv
